### sv/t2rgb_pkg.sv
package t2rgb_pkg;

    localparam int NumStages = 9;

    // format codes
    localparam logic [2:0] FMT_RG16_MOTION = 3'd0;
    localparam logic [2:0] FMT_RG32_MOTION = 3'd1;
    localparam logic [2:0] FMT_RGBA16      = 3'd2;
    localparam logic [2:0] FMT_R32_DEPTH   = 3'd3;
    localparam logic [2:0] FMT_R11G11B10   = 3'd4;

    localparam logic [7:0]  MOTION_MID = 8'd128;
    localparam logic [14:0] HALF_ONE   = 15'h3C00;
    localparam logic [30:0] SINGLE_ONE = 31'h3F800000;

    typedef logic [14:0] gam_tab_t [256];
    typedef logic [30:0] dep_tab_t [256];

    // decoded motion channel
    typedef struct packed {
        logic        nan;
        logic        zero;
        logic        sat;
        logic        neg;
        logic [34:0] prod;   // mantissa * 2040
        logic [7:0]  sh;     // binary exponent, negated
    } mot_t;

    typedef struct packed {
        logic [2:0]       fmt;
        logic [23:0]      raw;
        logic             depth;
        logic [2:0][30:0] key;
        logic [2:0][7:0]  acc;
        mot_t [1:0]       mot;
        logic [1:0][7:0]  mbyte;
    } pipe_t;

    function automatic logic [255:0] ipow(input logic [255:0] b, input int n);
        logic [255:0] r;
        r = 256'd1;
        for (int i = 0; i < n; i++)
        begin
            r = r * b;
        end
        return r;
    endfunction

    // half pattern at or above ((2k-1)/510)^(11/5)
    function automatic logic gam_test(input logic [14:0] h, input int k);
        logic [255:0] m;
        logic [255:0] lhs;
        logic [255:0] rhs;
        int           s;
        if (h[14:10] == 5'd0)
        begin
            m = {246'd0, h[9:0]};
            s = 24;
        end
        else
        begin
            m = {245'd0, 1'b1, h[9:0]};
            s = 25 - int'(h[14:10]);
        end
        lhs = ipow(m, 5) * ipow(256'd510, 11);
        rhs = ipow(256'(2 * k - 1), 11) << (5 * s);
        return lhs >= rhs;
    endfunction

    function automatic logic dep_test(input logic [30:0] b, input int k);
        logic [255:0] m;
        logic [255:0] lhs;
        logic [255:0] rhs;
        int           s;
        if (b[30:23] == 8'd0)
        begin
            m = {233'd0, b[22:0]};
            s = 149;
        end
        else
        begin
            m = {232'd0, 1'b1, b[22:0]};
            s = 150 - int'(b[30:23]);
        end
        lhs = m * ipow(256'd510, 4);
        rhs = ipow(256'(2 * k - 1), 4) << s;
        return lhs >= rhs;
    endfunction

    // smallest pattern reaching each output code, worked out at elaboration
    function automatic gam_tab_t gamma_table();
        gam_tab_t t;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [14:0] mid;
        t[0] = 15'd0;
        for (int k = 1; k < 256; k++)
        begin
            lo = 15'd0;
            hi = HALF_ONE;
            while (lo < hi)
            begin
                mid = 15'((16'(lo) + 16'(hi)) >> 1);
                if (gam_test(mid, k))
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 15'd1;
                end
            end
            t[k] = lo;
        end
        return t;
    endfunction

    function automatic dep_tab_t depth_table();
        dep_tab_t t;
        logic [30:0] lo;
        logic [30:0] hi;
        logic [30:0] mid;
        t[0] = 31'd0;
        for (int k = 1; k < 256; k++)
        begin
            lo = 31'd0;
            hi = SINGLE_ONE;
            while (lo < hi)
            begin
                mid = 31'((32'(lo) + 32'(hi)) >> 1);
                if (dep_test(mid, k))
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 31'd1;
                end
            end
            t[k] = lo;
        end
        return t;
    endfunction

    localparam gam_tab_t GAMMA_T = gamma_table();
    localparam dep_tab_t DEPTH_T = depth_table();

    function automatic mot_t dec_half_mot(input logic [15:0] h);
        mot_t        r;
        logic [23:0] m;
        r.neg  = h[15];
        r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        r.zero = (h[14:0] == 15'd0);
        r.sat  = (h[14:10] >= 5'd25);
        if (h[14:10] == 5'd0)
        begin
            m    = {14'd0, h[9:0]};
            r.sh = 8'd24;
        end
        else
        begin
            m    = {13'd0, 1'b1, h[9:0]};
            r.sh = 8'd25 - {3'd0, h[14:10]};
        end
        r.prod = ({11'd0, m} << 11) - ({11'd0, m} << 3);
        return r;
    endfunction

    function automatic mot_t dec_single_mot(input logic [31:0] b);
        mot_t        r;
        logic [23:0] m;
        r.neg  = b[31];
        r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        r.zero = (b[30:0] == 31'd0);
        r.sat  = (b[30:23] >= 8'd150);
        if (b[30:23] == 8'd0)
        begin
            m    = {1'b0, b[22:0]};
            r.sh = 8'd149;
        end
        else
        begin
            m    = {1'b1, b[22:0]};
            r.sh = 8'd150 - b[30:23];
        end
        r.prod = ({11'd0, m} << 11) - ({11'd0, m} << 3);
        return r;
    endfunction

    // floor(128 + 2040 x), clamped
    function automatic logic [7:0] motion_byte(input mot_t v);
        logic [34:0] q;
        logic        rem;
        logic [7:0]  r;
        if (v.sh >= 8'd35)
        begin
            q   = 35'd0;
            rem = 1'b1;
        end
        else
        begin
            q   = v.prod >> v.sh[5:0];
            rem = (v.prod & ((35'd1 << v.sh[5:0]) - 35'd1)) != 35'd0;
        end
        if (v.nan)
        begin
            r = 8'd0;
        end
        else if (v.zero)
        begin
            r = MOTION_MID;
        end
        else if (v.sat)
        begin
            r = v.neg ? 8'd0 : 8'd255;
        end
        else if (!v.neg)
        begin
            r = (q >= 35'd127) ? 8'd255 : MOTION_MID + q[7:0];
        end
        else
        begin
            r = (q >= 35'd128) ? 8'd0 : MOTION_MID - q[7:0] - {7'd0, rem};
        end
        return r;
    endfunction

    // key for a curve lane: non-negative, non-NaN pattern, else zero
    function automatic logic [30:0] half_key(input logic [15:0] h);
        logic nan;
        nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        return (h[15] || nan) ? 31'd0 : {16'd0, h[14:0]};
    endfunction

endpackage

### sv/texel_to_rgb8_preview_unit.sv
// throughput: one texel per cycle while m_tready is high; each stage takes a new item whenever it
// is empty or its contents move on, so bubbles close up under a stall
// reset: rst_n clears every stage valid bit at once; payload registers are not reset
module texel_to_rgb8_preview_unit
    import t2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // texel_bits[63:0]
    input  logic [2:0]  s_tuser,   // format_code[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // stage 0 holds the decoded texel, stages 1..8 each resolve one bit of
    // the output codes by a binary search over the threshold tables
    pipe_t                 stage_reg  [NumStages];
    pipe_t                 stage_next [NumStages];
    logic [NumStages-1:0]  vld_reg;
    logic [NumStages:0]    rdy;

    pipe_t                 dec;
    logic [31:0]           lo32;

    // per-stage ready: a stage loads when empty or when it drains
    always_comb
    begin
        rdy[NumStages] = m_tready;
        for (int i = NumStages - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i + 1];
        end
    end

    assign s_tready = rdy[0];

    // input decode: curve keys, motion products, raw bytes
    always_comb
    begin
        lo32       = s_tdata[31:0];
        dec        = '0;
        dec.fmt    = s_tuser;
        dec.raw    = lo32[23:0];
        dec.depth  = (s_tuser == FMT_R32_DEPTH);
        dec.mot[0] = dec_half_mot(lo32[15:0]);
        dec.mot[1] = dec_half_mot(lo32[31:16]);
        if (s_tuser == FMT_RG32_MOTION)
        begin
            dec.mot[0] = dec_single_mot(lo32);
            dec.mot[1] = dec_single_mot(s_tdata[63:32]);
        end
        unique case (s_tuser)
            FMT_R32_DEPTH:
            begin
                // negative or NaN depth gives 0; +inf is above every threshold
                if (lo32[31] || ((lo32[30:23] == 8'hFF) && (lo32[22:0] != 23'd0)))
                begin
                    dec.key[0] = 31'd0;
                end
                else
                begin
                    dec.key[0] = lo32[30:0];
                end
            end
            FMT_R11G11B10:
            begin
                // packed floats widen to halves by a left shift
                dec.key[0] = half_key({1'b0, lo32[10:0], 4'd0});
                dec.key[1] = half_key({1'b0, lo32[21:11], 4'd0});
                dec.key[2] = half_key({1'b0, lo32[31:22], 5'd0});
            end
            default:
            begin
                dec.key[0] = half_key(lo32[15:0]);
                dec.key[1] = half_key(lo32[31:16]);
                dec.key[2] = half_key(s_tdata[47:32]);
            end
        endcase
    end

    // search steps; motion bytes are settled in the first of them
    always_comb
    begin
        logic [7:0]  cand;
        logic [30:0] thr;
        stage_next[0] = dec;
        for (int j = 1; j < NumStages; j++)
        begin
            stage_next[j] = stage_reg[j - 1];
            if (j == 1)
            begin
                stage_next[j].mbyte[0] = motion_byte(stage_reg[j - 1].mot[0]);
                stage_next[j].mbyte[1] = motion_byte(stage_reg[j - 1].mot[1]);
            end
            for (int l = 0; l < 3; l++)
            begin
                cand = stage_reg[j - 1].acc[l] | (8'd1 << (NumStages - 1 - j));
                thr  = stage_reg[j - 1].depth ? DEPTH_T[cand] : {16'd0, GAMMA_T[cand]};
                if (stage_reg[j - 1].key[l] >= thr)
                begin
                    stage_next[j].acc[l] = cand;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NumStages; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NumStages; i++)
        begin
            if (rdy[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // output selection from the last stage register
    assign m_tvalid = vld_reg[NumStages - 1];

    always_comb
    begin
        pipe_t p;
        p = stage_reg[NumStages - 1];
        unique case (p.fmt)
            FMT_RG16_MOTION, FMT_RG32_MOTION:
            begin
                m_tdata = {MOTION_MID, p.mbyte[1], p.mbyte[0]};
            end
            FMT_RGBA16, FMT_R11G11B10:
            begin
                m_tdata = {p.acc[2], p.acc[1], p.acc[0]};
            end
            FMT_R32_DEPTH:
            begin
                // grey
                m_tdata = {p.acc[0], p.acc[0], p.acc[0]};
            end
            default:
            begin
                m_tdata = p.raw;
            end
        endcase
    end

endmodule

### tb/texel_to_rgb8_preview_unit_tb.sv
`timescale 1ns / 1ps

module texel_to_rgb8_preview_unit_tb
    import t2rgb_pkg::*;
();

    localparam int RandomItems = 600;
    localparam int QuietItems  = 100;      // last stretch runs with no idling
    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 30;       // well over the pipeline depth
    localparam int HoldCycles  = 80;       // long receiver hold-off
    localparam logic [2:0] FMT_RAW     = 3'd5;
    localparam logic [2:0] FMT_SPARE_A = 3'd6;
    localparam logic [2:0] FMT_SPARE_B = 3'd7;

    typedef enum int {K_ZERO, K_FINITE, K_INF, K_NAN} num_kind_e;

    typedef struct {
        num_kind_e       kind;
        bit              neg;
        longint unsigned m;
        int              e;
    } fnum_t;

    // matches the packing of m_tdata: red lowest
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct {
        logic [2:0]  fmt;
        logic [63:0] texel;
        bit          typed;
        rgb_t        want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    rgb_t      pending_rgb[$];
    stim_row_t directed[$];
    int        errors = 0;
    int        cycles = 0;
    int        accepted = 0;
    bit        quiet;

    texel_to_rgb8_preview_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------
    // colour predictor
    // ---------------------------------------------------------------

    function automatic fnum_t unpack_half(input logic [15:0] h);
        fnum_t r;
        r.neg = h[15];
        r.m   = 0;
        r.e   = 0;
        if (h[14:10] == 5'h1F)
        begin
            r.kind = (h[9:0] != 0) ? K_NAN : K_INF;
        end
        else if (h[14:10] == 5'd0)
        begin
            r.kind = (h[9:0] != 0) ? K_FINITE : K_ZERO;
            r.m    = h[9:0];
            r.e    = -24;
        end
        else
        begin
            r.kind = K_FINITE;
            r.m    = {1'b1, h[9:0]};
            r.e    = int'(h[14:10]) - 25;
        end
        return r;
    endfunction

    function automatic fnum_t unpack_single(input logic [31:0] b);
        fnum_t r;
        r.neg = b[31];
        r.m   = 0;
        r.e   = 0;
        if (b[30:23] == 8'hFF)
        begin
            r.kind = (b[22:0] != 0) ? K_NAN : K_INF;
        end
        else if (b[30:23] == 8'd0)
        begin
            r.kind = (b[22:0] != 0) ? K_FINITE : K_ZERO;
            r.m    = b[22:0];
            r.e    = -149;
        end
        else
        begin
            r.kind = K_FINITE;
            r.m    = {1'b1, b[22:0]};
            r.e    = int'(b[30:23]) - 150;
        end
        return r;
    endfunction

    function automatic bit [255:0] wide_pow(input bit [255:0] b, input int n);
        bit [255:0] r;
        r = 256'd1;
        for (int i = 0; i < n; i++)
        begin
            r = r * b;
        end
        return r;
    endfunction

    // largest code whose half-step threshold the value reaches, by exact compare
    function automatic logic [7:0] tone_curve(input fnum_t v, input int p, input int q);
        bit [255:0] lhs;
        bit [255:0] rhs;
        int         s;
        int         sh;
        int         lo;
        int         hi;
        int         mid;
        if (v.kind == K_NAN || v.kind == K_ZERO || v.neg)
        begin
            return 8'd0;
        end
        if (v.kind == K_INF || v.e >= 0)
        begin
            return 8'd255;
        end
        s = -v.e;
        if (s < 32 && v.m >= (64'd1 << s))
        begin
            return 8'd255;
        end
        sh = p * s;
        if (sh >= 256)
        begin
            return 8'd0;
        end
        lhs = wide_pow(256'(v.m), p) * wide_pow(256'd510, q);
        lo  = 0;
        hi  = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            rhs = wide_pow(256'(2 * mid - 1), q) << sh;
            if (lhs >= rhs)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return 8'(lo);
    endfunction

    // floor(128 + 2040 x), clamped to a byte
    function automatic logic [7:0] motion_level(input fnum_t v);
        longint unsigned t;
        longint unsigned qv;
        bit              rem;
        longint          r;
        int              s;
        if (v.kind == K_NAN)
        begin
            return 8'd0;
        end
        if (v.kind == K_ZERO)
        begin
            return 8'd128;
        end
        if (v.kind == K_INF || v.e >= 0)
        begin
            return v.neg ? 8'd0 : 8'd255;
        end
        t = v.m * 2040;
        s = -v.e;
        if (s < 64)
        begin
            qv  = t >> s;
            rem = (t & ((64'd1 << s) - 1)) != 0;
        end
        else
        begin
            qv  = 0;
            rem = t != 0;
        end
        if (qv > 1000)
        begin
            qv = 1000;
        end
        r = v.neg ? 128 - longint'(qv) - longint'(rem) : 128 + longint'(qv);
        if (r < 0)
        begin
            r = 0;
        end
        if (r > 255)
        begin
            r = 255;
        end
        return 8'(r);
    endfunction

    // packed 11/11/10 channel widened into a half pattern
    function automatic fnum_t widen_small_float(input logic [10:0] c, input int shift);
        logic [31:0] h;
        h = ({21'd0, c} << shift) & 32'h7FF0;
        return unpack_half(h[15:0]);
    endfunction

    function automatic rgb_t preview_colour(input logic [2:0] fmt, input logic [63:0] tx);
        rgb_t c;
        case (fmt)
            FMT_RG16_MOTION:
            begin
                c.red   = motion_level(unpack_half(tx[15:0]));
                c.green = motion_level(unpack_half(tx[31:16]));
                c.blue  = 8'd128;
            end
            FMT_RG32_MOTION:
            begin
                c.red   = motion_level(unpack_single(tx[31:0]));
                c.green = motion_level(unpack_single(tx[63:32]));
                c.blue  = 8'd128;
            end
            FMT_RGBA16:
            begin
                c.red   = tone_curve(unpack_half(tx[15:0]), 5, 11);
                c.green = tone_curve(unpack_half(tx[31:16]), 5, 11);
                c.blue  = tone_curve(unpack_half(tx[47:32]), 5, 11);
            end
            FMT_R32_DEPTH:
            begin
                c.red   = tone_curve(unpack_single(tx[31:0]), 1, 4);
                c.green = c.red;
                c.blue  = c.red;
            end
            FMT_R11G11B10:
            begin
                c.red   = tone_curve(widen_small_float(tx[10:0], 4), 5, 11);
                c.green = tone_curve(widen_small_float(tx[21:11], 4), 5, 11);
                c.blue  = tone_curve(widen_small_float({1'b0, tx[31:22]}, 5), 5, 11);
            end
            default:
            begin
                c.red   = tx[7:0];
                c.green = tx[15:8];
                c.blue  = tx[23:16];
            end
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------
    // random texel content, biased towards the interesting ranges
    // ---------------------------------------------------------------

    function automatic logic [15:0] pick_half();
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom);
        end
        return {1'($urandom_range(0, 7) == 0), 5'($urandom_range(0, 16)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] pick_single(input int elo, input int ehi);
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return {1'($urandom_range(0, 3) == 0), 8'($urandom_range(elo, ehi)), 23'($urandom)};
    endfunction

    function automatic logic [63:0] pick_texel(input logic [2:0] fmt);
        logic [63:0] tx;
        tx = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
        begin
            return tx;                     // plain noise over every bit
        end
        case (fmt)
            FMT_RG16_MOTION: tx[31:0] = {pick_half(), pick_half()};
            FMT_RG32_MOTION: tx = {pick_single(110, 152), pick_single(110, 152)};
            FMT_RGBA16:      tx[47:0] = {pick_half(), pick_half(), pick_half()};
            FMT_R32_DEPTH:   tx[31:0] = pick_single(90, 128);
            FMT_R11G11B10:
            begin
                tx[10:0]  = {5'($urandom_range(0, 16)), 6'($urandom)};
                tx[21:11] = {5'($urandom_range(0, 16)), 6'($urandom)};
                tx[31:22] = {5'($urandom_range(0, 16)), 5'($urandom)};
            end
            default: ;
        endcase
        return tx;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_rgb.size() == 0)
            begin
                $display("unexpected output transaction at cycle %0d: %h", cycles, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                begin
                    report("red", got.red, want.red);
                end
                if (got.green !== want.green)
                begin
                    report("green", got.green, want.green);
                end
                if (got.blue !== want.blue)
                begin
                    report("blue", got.blue, want.blue);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off
    // ---------------------------------------------------------------

    initial
    begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!held && accepted >= 150)
            begin
                // long stall so the pipeline fills and pushes back on the input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    task automatic send_texel(input logic [2:0] fmt, input logic [63:0] tx, input rgb_t want);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fmt;
        s_tdata  <= tx;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_rgb.insert(pending_rgb.size(), want);
        accepted++;
    endtask

    function automatic stim_row_t row(input logic [2:0] fmt, input logic [63:0] tx,
                                      input bit typed, input rgb_t want);
        stim_row_t r;
        r.fmt   = fmt;
        r.texel = tx;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] fmt, input logic [63:0] tx,
                           input bit typed, input rgb_t want);
        directed.insert(directed.size(), row(fmt, tx, typed, want));
    endtask

    initial
    begin
        logic [2:0] fmt;
        rgb_t       want;
        quiet    = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        // raw bytes and the unused codes
        add_row(FMT_RAW, 64'hDEAD_BEEF_0033_2211, 1, {8'h33, 8'h22, 8'h11});
        add_row(FMT_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF, 1, {8'hFF, 8'hFF, 8'hFF});
        add_row(FMT_SPARE_B, 64'h0, 1, {8'h00, 8'h00, 8'h00});
        // motion: zero, not a number, infinities, minus zero
        add_row(FMT_RG16_MOTION, 64'h0, 1, {8'd128, 8'd128, 8'd128});
        add_row(FMT_RG16_MOTION, 64'h7C00_7E01, 1, {8'd128, 8'd255, 8'd0});
        add_row(FMT_RG16_MOTION, 64'h8000_FC00, 1, {8'd128, 8'd128, 8'd0});
        add_row(FMT_RG32_MOTION, 64'hFF80_0000_7FC0_0000, 1, {8'd128, 8'd0, 8'd0});
        add_row(FMT_RG32_MOTION, 64'hBD00_0000_3D00_0000, 0, '0);
        add_row(FMT_RG32_MOTION, 64'h8000_0001_0000_0001, 0, '0);
        add_row(FMT_RG16_MOTION, 64'h83FF_03FF, 0, '0);
        // rgba half: nan, infinity, one; denormals, negatives
        add_row(FMT_RGBA16, 64'hFFFF_3C00_7C00_7E00, 1, {8'd255, 8'd255, 8'd0});
        add_row(FMT_RGBA16, 64'h0000_8400_03FF_0001, 0, '0);
        add_row(FMT_RGBA16, 64'h1234_FFFF_3400_3800, 0, '0);
        add_row(FMT_RGBA16, 64'h0000_3BFF_0400_0000, 0, '0);
        // depth: one, zero, negative, nan, smallest denormal, a quarter
        add_row(FMT_R32_DEPTH, 64'h3F80_0000, 1, {8'd255, 8'd255, 8'd255});
        add_row(FMT_R32_DEPTH, 64'h0, 1, {8'd0, 8'd0, 8'd0});
        add_row(FMT_R32_DEPTH, 64'hBF00_0000, 1, {8'd0, 8'd0, 8'd0});
        add_row(FMT_R32_DEPTH, 64'h7FFF_FFFF, 1, {8'd0, 8'd0, 8'd0});
        add_row(FMT_R32_DEPTH, 64'h0000_0001, 0, '0);
        add_row(FMT_R32_DEPTH, 64'h3E80_0000, 0, '0);
        // packed small floats: all nan, zero, infinity on red, denormals
        add_row(FMT_R11G11B10, 64'hFFFF_FFFF, 1, {8'd0, 8'd0, 8'd0});
        add_row(FMT_R11G11B10, 64'h0, 1, {8'd0, 8'd0, 8'd0});
        add_row(FMT_R11G11B10, 64'h0000_07C0, 1, {8'd0, 8'd0, 8'd255});
        add_row(FMT_R11G11B10, 64'h0040_0801, 0, '0);
        add_row(FMT_R11G11B10, 64'h7BEF_77BF, 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            want = directed[i].typed ? directed[i].want
                                     : preview_colour(directed[i].fmt, directed[i].texel);
            send_texel(directed[i].fmt, directed[i].texel, want);
        end

        for (int n = 0; n < RandomItems; n++)
        begin
            logic [63:0] tx;
            quiet = (n >= RandomItems - QuietItems);
            fmt   = 3'($urandom_range(0, 7));
            tx    = pick_texel(fmt);
            send_texel(fmt, tx, preview_colour(fmt, tx));
        end
        s_tvalid <= 1'b0;

        while (pending_rgb.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
